### design/hfe_pkg.sv
// Shared types and constants of the HDLC frame encoder with CRC-16.
// Used by hfe_front, hfe_queue, hfe_back and the top level; no dependencies.
package hfe_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_MASK  = 8'h20;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h8408;

   typedef logic [255:0][15:0] crc_table_type;

   typedef struct packed {
      logic        open_flag;
      logic [7:0]  data;
      logic        last;
      logic [15:0] crc;
   } job_type;

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_CLOSE
   } phase_type;

   function automatic crc_table_type crc_table_build();
      crc_table_type tbl;
      logic [15:0]   v;
      for (int i = 0; i < 256; i++) begin
         v = 16'(i);
         for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
               v = (v >> 1) ^ CRC_POLY;
            end else begin
               v = v >> 1;
            end
         end
         tbl[i] = v;
      end
      return tbl;
   endfunction

endpackage

### design/hfe_front.sv
// Front end: accepts payload beats, opens frames and runs the CRC-16.
// Depends on hfe_pkg; hands one job per beat to hfe_queue.
module hfe_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_payload_byte,
   input  logic            req_frame_last,
   output logic            push_valid,
   output hfe_pkg::job_type push_job,
   input  logic            push_full
);

   localparam hfe_pkg::crc_table_type CRC_TABLE = hfe_pkg::crc_table_build();

   logic [15:0] crc_ff, crc_in;
   logic        inside_ff, inside_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;

   assign req_stall  = push_full;
   assign push_valid = req_valid & ~push_full;

   always_comb begin
      crc_base = inside_ff ? crc_ff : hfe_pkg::CRC_INIT;
      crc_next = CRC_TABLE[req_payload_byte ^ crc_base[15:8]] ^ {crc_base[7:0], 8'h00};
      push_job.open_flag = ~inside_ff;
      push_job.data      = req_payload_byte;
      push_job.last      = req_frame_last;
      push_job.crc       = crc_next;
   end

   always_comb begin
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (push_valid) begin
         if (req_frame_last) begin
            crc_in    = hfe_pkg::CRC_INIT;
            inside_in = 1'b0;
         end else begin
            crc_in    = crc_next;
            inside_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= hfe_pkg::CRC_INIT;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         inside_ff <= inside_in;
      end
   end

endmodule

### design/hfe_queue.sv
// Short job queue between the front end and the line sequencer.
// Depends on hfe_pkg for the job type.
module hfe_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hfe_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output hfe_pkg::job_type head_job,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hfe_pkg::job_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/hfe_back.sv
// Line sequencer: turns one queued job into flag, escaped data, CRC and closing flag
// beats, one per cycle unless stalled, via an output register. Depends on hfe_pkg.
module hfe_back (
   input  logic             clock,
   input  logic             reset,
   input  hfe_pkg::job_type job,
   input  logic             job_valid,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_line_byte,
   output logic             rsp_run_last
);

   hfe_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic               esc_ff, esc_in;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_line_byte_ff, rsp_line_byte_in;
   logic               rsp_run_last_ff, rsp_run_last_in;
   logic               load;
   logic               emit;
   logic [7:0]         raw_byte;
   logic               esc_need;
   logic               job_done;

   assign load = ~rsp_valid_ff | ~rsp_stall;
   assign emit = job_valid & load;

   always_comb begin
      cur_phase = phase_ff;
      if (phase_ff == hfe_pkg::PH_OPEN && !job.open_flag) begin
         cur_phase = hfe_pkg::PH_DATA;
      end
      case (cur_phase)
         hfe_pkg::PH_OPEN:   raw_byte = hfe_pkg::FLAG_BYTE;
         hfe_pkg::PH_DATA:   raw_byte = job.data;
         hfe_pkg::PH_CRC_HI: raw_byte = job.crc[15:8];
         hfe_pkg::PH_CRC_LO: raw_byte = job.crc[7:0];
         hfe_pkg::PH_CLOSE:  raw_byte = hfe_pkg::FLAG_BYTE;
         default:            raw_byte = hfe_pkg::FLAG_BYTE;
      endcase
      esc_need = (cur_phase == hfe_pkg::PH_DATA || cur_phase == hfe_pkg::PH_CRC_HI ||
                  cur_phase == hfe_pkg::PH_CRC_LO) &&
                 (raw_byte == hfe_pkg::FLAG_BYTE || raw_byte == hfe_pkg::ESC_BYTE);
      job_done = ~(esc_need & ~esc_ff) &
                 ((cur_phase == hfe_pkg::PH_DATA && !job.last) ||
                  cur_phase == hfe_pkg::PH_CLOSE);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      if (emit) begin
         if (esc_need && !esc_ff) begin
            phase_in = cur_phase;
            esc_in   = 1'b1;
         end else begin
            esc_in = 1'b0;
            case (cur_phase)
               hfe_pkg::PH_OPEN:   phase_in = hfe_pkg::PH_DATA;
               hfe_pkg::PH_DATA:   phase_in = job.last ? hfe_pkg::PH_CRC_HI
                                                       : hfe_pkg::PH_OPEN;
               hfe_pkg::PH_CRC_HI: phase_in = hfe_pkg::PH_CRC_LO;
               hfe_pkg::PH_CRC_LO: phase_in = hfe_pkg::PH_CLOSE;
               hfe_pkg::PH_CLOSE:  phase_in = hfe_pkg::PH_OPEN;
               default:            phase_in = hfe_pkg::PH_OPEN;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      job_pop          = emit & job_done;
      rsp_line_byte_in = rsp_line_byte_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      if (emit) begin
         if (esc_need && !esc_ff) begin
            rsp_line_byte_in = hfe_pkg::ESC_BYTE;
         end else if (esc_ff) begin
            rsp_line_byte_in = raw_byte ^ hfe_pkg::ESC_MASK;
         end else begin
            rsp_line_byte_in = raw_byte;
         end
         rsp_run_last_in = job_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hfe_pkg::PH_OPEN;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         if (load) begin
            rsp_valid_ff <= job_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_line_byte_ff <= rsp_line_byte_in;
      rsp_run_last_ff  <= rsp_run_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = rsp_line_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;

endmodule

### design/hdlc_frame_encoder_crc16.sv
// Channel  Direction  Ports                                         One beat
// req      in         req_valid req_stall req_payload_byte          one payload byte
//                     req_frame_last
// rsp      out        rsp_valid rsp_stall rsp_line_byte rsp_run_last one line byte
//
// The sequencer sends one line byte per cycle while rsp_stall is low, so an item gives 1 to 8
// line bytes (flag, data and escapes, CRC bytes with escapes, closing flag).
// The front end takes a beat every cycle while the job queue has room.
// Reset clears the queue and the output register, sets the CRC to 0xFFFF, closes the frame.
// rsp_stall holds the output register; the queue then fills and raises req_stall.
module hdlc_frame_encoder_crc16 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_frame_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_run_last
);

   logic             push_valid;
   hfe_pkg::job_type push_job;
   logic             queue_full;
   logic             queue_empty;
   hfe_pkg::job_type head_job;
   logic             job_pop;

   hfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_frame_last   (req_frame_last),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .push_full        (queue_full)
   );

   hfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   hfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (head_job),
      .job_valid     (~queue_empty),
      .job_pop       (job_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_line_byte (rsp_line_byte),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

### design/hfe_checker.sv
// Port-level checks for hdlc_frame_encoder_crc16, bound to the top level.
// Depends on hfe_pkg for the escape byte.
module hfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_payload_byte,
   input logic       req_frame_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_line_byte,
   input logic       rsp_run_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_byte) && $stable(rsp_run_last))
      else $error("rsp beat changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload_byte) &&
                                 $stable(req_frame_last))
      else $error("req beat changed while stalled");

   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_byte == hfe_pkg::ESC_BYTE |-> !rsp_run_last)
      else $error("escape byte ended a run");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind hdlc_frame_encoder_crc16 hfe_checker u_checker (.*);

### verif/hdlc_frame_encoder_crc16_tb.sv
// Testbench for hdlc_frame_encoder_crc16: directed beats from a table, then random frames.
// Checks each line byte against the table or a local HDLC/CRC-16 model; needs hfe_pkg and RTL.
`timescale 1ns / 100ps

module hdlc_frame_encoder_crc16_tb;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
   } line_type;

   typedef struct packed {
      logic [7:0]      payload;
      logic            last;
      logic [3:0]      n_typed;
      logic [0:3][7:0] typed;
   } dir_row_type;

   localparam int      DIR_ROWS = 20;
   localparam int      RANDOM_BEATS = 350;
   localparam int      HOLD_OFF_BEAT = 120;
   localparam int      HOLD_OFF_CYCLES = 300;
   localparam int      DRAIN_LIMIT = 5000;
   localparam int      TAIL_CYCLES = 20;

   // n_typed = 0: take the line bytes from the encoder model
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{8'h00, 1'b0, 4'd2, 32'h7E00_0000},
      '{8'hFF, 1'b0, 4'd1, 32'hFF00_0000},
      '{8'h7E, 1'b0, 4'd2, 32'h7D5E_0000},
      '{8'h7D, 1'b0, 4'd2, 32'h7D5D_0000},
      '{8'h20, 1'b1, 4'd0, 32'h0},
      '{8'h7E, 1'b0, 4'd3, 32'h7E7D_5E00},
      '{8'h5E, 1'b1, 4'd0, 32'h0},
      '{8'h00, 1'b1, 4'd0, 32'h0},
      '{8'hFF, 1'b1, 4'd0, 32'h0},
      '{8'h7D, 1'b1, 4'd0, 32'h0},
      '{8'h7E, 1'b1, 4'd0, 32'h0},
      '{8'h55, 1'b0, 4'd2, 32'h7E55_0000},
      '{8'hAA, 1'b0, 4'd1, 32'hAA00_0000},
      '{8'h01, 1'b0, 4'd1, 32'h0100_0000},
      '{8'h80, 1'b0, 4'd1, 32'h8000_0000},
      '{8'h5D, 1'b1, 4'd0, 32'h0},
      '{8'h7F, 1'b1, 4'd0, 32'h0},
      '{8'h7C, 1'b0, 4'd2, 32'h7E7C_0000},
      '{8'h20, 1'b0, 4'd1, 32'h2000_0000},
      '{8'hFE, 1'b1, 4'd0, 32'h0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_payload_byte = 8'h00;
   logic       req_frame_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_line_byte;
   logic       rsp_run_last;

   logic [15:0] enc_crc = hfe_pkg::CRC_INIT;
   logic        enc_open = 1'b0;
   line_type    enc_out[$];
   line_type    pending_line[$];
   int          line_errors = 0;

   hdlc_frame_encoder_crc16 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_run_last     (rsp_run_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] t;
      t = {8'h00, b ^ crc[15:8]};
      for (int k = 0; k < 8; k++) begin
         t = t[0] ? ((t >> 1) ^ hfe_pkg::CRC_POLY) : (t >> 1);
      end
      return t ^ {crc[7:0], 8'h00};
   endfunction

   function automatic void emit_raw(logic [7:0] b);
      enc_out.push_back('{b, 1'b0});
   endfunction

   function automatic void emit_escaped(logic [7:0] b);
      if (b == hfe_pkg::FLAG_BYTE || b == hfe_pkg::ESC_BYTE) begin
         emit_raw(hfe_pkg::ESC_BYTE);
         emit_raw(b ^ hfe_pkg::ESC_MASK);
      end else begin
         emit_raw(b);
      end
   endfunction

   function automatic void hdlc_encode(logic [7:0] b, logic l);
      enc_out.delete();
      if (!enc_open) begin
         emit_raw(hfe_pkg::FLAG_BYTE);
         enc_open = 1'b1;
         enc_crc = hfe_pkg::CRC_INIT;
      end
      enc_crc = crc_step(enc_crc, b);
      emit_escaped(b);
      if (l) begin
         emit_escaped(enc_crc[15:8]);
         emit_escaped(enc_crc[7:0]);
         emit_raw(hfe_pkg::FLAG_BYTE);
         enc_crc = hfe_pkg::CRC_INIT;
         enc_open = 1'b0;
      end
      enc_out[enc_out.size() - 1].run_last = 1'b1;
   endfunction

   // pick a closing byte that leaves a CRC byte needing an escape; -1 if none
   function automatic int crc_escape_tail(logic [15:0] crc);
      logic [15:0] nxt;
      logic [7:0]  cand;
      int          start;
      start = $urandom_range(0, 255);
      for (int i = 0; i < 256; i++) begin
         cand = 8'(start + i);
         nxt = crc_step(crc, cand);
         if (nxt[15:8] == hfe_pkg::FLAG_BYTE || nxt[15:8] == hfe_pkg::ESC_BYTE ||
             nxt[7:0] == hfe_pkg::FLAG_BYTE || nxt[7:0] == hfe_pkg::ESC_BYTE) begin
            return int'(cand);
         end
      end
      return -1;
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic l, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload_byte <= b;
      req_frame_last <= l;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   initial begin : line_sink
      line_type want;
      int       hold;
      int       beats;
      bit       sink_quiet;
      beats = 0;
      sink_quiet = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (beats % 40 == 0) begin
            sink_quiet = ($urandom_range(0, 3) == 0);
         end
         if (beats == HOLD_OFF_BEAT) begin
            hold = HOLD_OFF_CYCLES;
         end else begin
            hold = sink_quiet ? 0 : $urandom_range(0, 16);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         beats++;
         if (pending_line.size() == 0) begin
            line_errors++;
            $display("%0t: unexpected beat, expected none, actual line_byte %h run_last %b",
                     $time, rsp_line_byte, rsp_run_last);
         end else begin
            want = pending_line.pop_front();
            if (rsp_line_byte !== want.line_byte) begin
               line_errors++;
               $display("%0t: line_byte mismatch, expected %h, actual %h",
                        $time, want.line_byte, rsp_line_byte);
            end
            if (rsp_run_last !== want.run_last) begin
               line_errors++;
               $display("%0t: run_last mismatch, expected %b, actual %b",
                        $time, want.run_last, rsp_run_last);
            end
         end
      end
   end

   initial begin : frame_source
      dir_row_type row;
      logic [7:0]  b;
      logic        l;
      int          sent;
      int          frame_len;
      int          tail;
      int          drain_cycles;
      bit          src_quiet;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIRECTED[r];
         send_beat(row.payload, row.last, $urandom_range(0, 16));
         hdlc_encode(row.payload, row.last);
         if (row.n_typed != 0) begin
            enc_out.delete();
            for (int k = 0; k < row.n_typed; k++) begin
               enc_out.push_back('{row.typed[k], 1'b0});
            end
            enc_out[enc_out.size() - 1].run_last = 1'b1;
         end
         foreach (enc_out[k]) pending_line.push_back(enc_out[k]);
      end

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         src_quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < frame_len; i++) begin
            l = (i == frame_len - 1);
            case ($urandom_range(0, 7))
               0: begin
                  b = hfe_pkg::FLAG_BYTE;
               end
               1: begin
                  b = hfe_pkg::ESC_BYTE;
               end
               default: begin
                  b = 8'($urandom_range(0, 255));
               end
            endcase
            if (l && $urandom_range(0, 3) == 0) begin
               tail = crc_escape_tail(enc_open ? enc_crc : hfe_pkg::CRC_INIT);
               if (tail >= 0) begin
                  b = 8'(tail);
               end
            end
            send_beat(b, l, src_quiet ? 0 : $urandom_range(0, 16));
            hdlc_encode(b, l);
            foreach (enc_out[k]) pending_line.push_back(enc_out[k]);
            sent++;
         end
      end
      req_valid <= 1'b0;

      drain_cycles = 0;
      while (pending_line.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (line_errors == 0 && pending_line.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (pending_line.size() != 0) begin
            $display("%0t: %0d expected beats never arrived, first expected %h",
                     $time, pending_line.size(), pending_line[0].line_byte);
         end
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
